@@ design/nfci_pkg.sv @@
// Package for the NOR flash command interface.
// Holds widths, command codes, request codes, mode and sequencer types and the shared structs.
// No dependencies.
`default_nettype none

package nfci_pkg;

	// Array geometry.
	localparam int ADDR_W       = 12;
	localparam int DATA_W       = 8;
	localparam int SECTOR_WORDS = 256;
	localparam int SECT_W       = $clog2(SECTOR_WORDS);
	localparam int TICK_W       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	// Unlock cycle addresses.
	localparam logic [ADDR_W-1:0] CYC1_ADDR = 12'h555;
	localparam logic [ADDR_W-1:0] CYC2_ADDR = 12'h2AA;

	// Command bytes.
	localparam logic [DATA_W-1:0] CMD_UNLOCK1     = 8'hAA;
	localparam logic [DATA_W-1:0] CMD_UNLOCK2     = 8'h55;
	localparam logic [DATA_W-1:0] CMD_AUTOSEL     = 8'h90;
	localparam logic [DATA_W-1:0] CMD_ERASE_SETUP = 8'h80;
	localparam logic [DATA_W-1:0] CMD_PROGRAM     = 8'hA0;
	localparam logic [DATA_W-1:0] CMD_SECTOR      = 8'h30;
	localparam logic [DATA_W-1:0] CMD_RESET       = 8'hF0;
	localparam logic [DATA_W-1:0] STATUS_BIT      = 8'h80;
	localparam logic [DATA_W-1:0] ERASED_WORD     = '1;

	// Request types.
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MANUF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 2'd2;

	// Command mode of the device.
	typedef enum logic [9:0] {
		M_READ        = 10'b00_0000_0001,
		M_UNL1        = 10'b00_0000_0010,
		M_UNL2        = 10'b00_0000_0100,
		M_AUTOSEL     = 10'b00_0000_1000,
		M_PROG_SETUP  = 10'b00_0001_0000,
		M_ERASE_SETUP = 10'b00_0010_0000,
		M_ERASE_UNL1  = 10'b00_0100_0000,
		M_ERASE_UNL2  = 10'b00_1000_0000,
		M_PROGRAMMING = 10'b01_0000_0000,
		M_ERASING     = 10'b10_0000_0000
	} mode_t;

	// Top level sequencer.
	typedef enum logic [2:0] {
		SEQ_CLEAR = 3'b001,
		SEQ_IDLE  = 3'b010,
		SEQ_EXEC  = 3'b100
	} seq_t;

	// One accepted item.
	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} item_t;

	// Configuration register set.
	typedef struct packed {
		logic [DATA_W-1:0] manuf;
		logic [DATA_W-1:0] device;
		logic [TICK_W-1:0] ticks;
	} cfg_t;

	// Array write request from the command logic.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_wr_t;

endpackage

`default_nettype wire

@@ design/nfci_array.sv @@
// Cell array of the flash bank: single-port synchronous memory.
// Depends on nfci_pkg for widths.
`default_nettype none

module nfci_array (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [nfci_pkg::ADDR_W-1:0] addr,
	input  wire logic [nfci_pkg::DATA_W-1:0] wdata,
	output logic      [nfci_pkg::DATA_W-1:0] rdata
);
	import nfci_pkg::*;

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write at the address, and register the word that is read there.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ design/nfci_core.sv @@
// Command decoder and operation state of the flash bank.
// Applies one item per exec cycle using the array word read for it. Depends on nfci_pkg.
`default_nettype none

module nfci_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        exec,
	input  wire nfci_pkg::item_t             item,
	input  wire nfci_pkg::cfg_t              cfg,
	input  wire logic [nfci_pkg::DATA_W-1:0] rdata,
	output nfci_pkg::mem_wr_t                mem_wr,
	output logic      [nfci_pkg::DATA_W-1:0] rd,
	output logic                             busy_nxt
);
	import nfci_pkg::*;

	mode_t             mode_q, mode_d;
	logic [TICK_W-1:0] bc_q, bc_d;
	logic [ADDR_W-1:0] ta_q, ta_d;
	logic [DATA_W-1:0] tv_q, tv_d;
	logic [SECT_W-1:0] pos_q, pos_d;

	// Decode the item against the current mode.
	always_comb begin
		mode_d = mode_q;
		bc_d   = bc_q;
		ta_d   = ta_q;
		tv_d   = tv_q;
		pos_d  = pos_q;
		rd     = '0;
		mem_wr = '0;
		case (item.req_type)
			REQ_READ: begin
				case (mode_q)
					M_AUTOSEL: begin
						if (item.addr == ADDR_W'(0)) begin
							rd = cfg.manuf;
						end else if (item.addr == ADDR_W'(1)) begin
							rd = cfg.device;
						end
					end
					M_PROGRAMMING: rd = ~tv_q & STATUS_BIT;
					M_ERASING:     rd = '0;
					default:       rd = rdata;
				endcase
			end
			REQ_WRITE: begin
				if (item.data == CMD_RESET) begin
					mode_d = M_READ;
					bc_d   = '0;
				end else begin
					case (mode_q)
						M_READ: begin
							if (item.addr == CYC1_ADDR && item.data == CMD_UNLOCK1) begin
								mode_d = M_UNL1;
							end
						end
						M_UNL1: begin
							mode_d = (item.addr == CYC2_ADDR && item.data == CMD_UNLOCK2)
								? M_UNL2 : M_READ;
						end
						M_UNL2: begin
							if (item.addr == CYC1_ADDR && item.data == CMD_AUTOSEL) begin
								mode_d = M_AUTOSEL;
							end else if (item.addr == CYC1_ADDR && item.data == CMD_PROGRAM) begin
								mode_d = M_PROG_SETUP;
							end else if (item.addr == CYC1_ADDR
									&& item.data == CMD_ERASE_SETUP) begin
								mode_d = M_ERASE_SETUP;
							end else begin
								mode_d = M_READ;
							end
						end
						M_PROG_SETUP: begin
							ta_d   = item.addr;
							tv_d   = rdata & item.data;
							bc_d   = cfg.ticks;
							mode_d = M_PROGRAMMING;
						end
						M_ERASE_SETUP: begin
							mode_d = (item.addr == CYC1_ADDR && item.data == CMD_UNLOCK1)
								? M_ERASE_UNL1 : M_READ;
						end
						M_ERASE_UNL1: begin
							mode_d = (item.addr == CYC2_ADDR && item.data == CMD_UNLOCK2)
								? M_ERASE_UNL2 : M_READ;
						end
						M_ERASE_UNL2: begin
							if (item.data == CMD_SECTOR) begin
								ta_d   = {item.addr[ADDR_W-1:SECT_W], SECT_W'(0)};
								pos_d  = '0;
								bc_d   = '0;
								mode_d = M_ERASING;
							end else begin
								mode_d = M_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			REQ_TICK: begin
				if (mode_q == M_PROGRAMMING) begin
					// A count of zero or one completes the program on this tick.
					if (bc_q <= TICK_W'(1)) begin
						mem_wr.we    = 1'b1;
						mem_wr.addr  = ta_q;
						mem_wr.wdata = tv_q;
						bc_d         = '0;
						mode_d       = M_READ;
					end else begin
						bc_d = bc_q - TICK_W'(1);
					end
				end else if (mode_q == M_ERASING) begin
					mem_wr.we    = 1'b1;
					mem_wr.addr  = ta_q + ADDR_W'(pos_q);
					mem_wr.wdata = ERASED_WORD;
					pos_d        = pos_q + SECT_W'(1);
					if (pos_q == SECT_W'(SECTOR_WORDS - 1)) begin
						pos_d  = '0;
						mode_d = M_READ;
					end
				end
			end
			default: begin
			end
		endcase
		busy_nxt = (mode_d == M_PROGRAMMING) || (mode_d == M_ERASING);
	end

	// Mode and operation registers, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_READ;
			bc_q   <= '0;
			ta_q   <= '0;
			tv_q   <= '0;
			pos_q  <= '0;
		end else if (exec) begin
			mode_q <= mode_d;
			bc_q   <= bc_d;
			ta_q   <= ta_d;
			tv_q   <= tv_d;
			pos_q  <= pos_d;
		end
	end

endmodule

`default_nettype wire

@@ design/nor_flash_command_interface.sv @@
// Command interface of a NOR flash bank: bus reads, bus writes and ticks against a word array.
// After reset the block sweeps all 4096 words to the erased value, one word per cycle, and
// keeps busy high for the whole sweep; configuration writes are taken during the sweep.
// Each item is then accepted while busy is low, and the next cycle applies it using the
// registered word read at its address from the single-port array; its result appears with
// done for exactly one cycle after that. A new item can be accepted in that same cycle, but
// not while the last one is being applied. The receiver cannot stall results.
// Depends on nfci_pkg, nfci_array and nfci_core.
`default_nettype none

module nor_flash_command_interface (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    req_type,
	input  wire logic [nfci_pkg::ADDR_W-1:0]   word_address,
	input  wire logic [nfci_pkg::DATA_W-1:0]   write_data,
	output logic                               done,
	output logic      [nfci_pkg::DATA_W-1:0]   read_data,
	output logic                               busy_res,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [nfci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nfci_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nfci_pkg::*;

	seq_t              seq_q;
	logic [ADDR_W-1:0] clr_q;
	item_t             item_s1;
	cfg_t              cfg_q;
	logic              accept;
	logic              exec;
	mem_wr_t           mem_wr;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] rd;
	logic              busy_nxt;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_wdata;

	assign busy      = (seq_q != SEQ_IDLE);
	assign accept    = start && !busy;
	assign exec      = (seq_q == SEQ_EXEC);
	assign cfg_ready = 1'b1;

	// Sequencer: clearing sweep, then idle and exec alternate per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_CLEAR;
			clr_q <= '0;
		end else begin
			case (seq_q)
				SEQ_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						seq_q <= SEQ_IDLE;
					end
				end
				SEQ_IDLE: begin
					if (start) begin
						seq_q <= SEQ_EXEC;
					end
				end
				SEQ_EXEC: seq_q <= SEQ_IDLE;
				default:  seq_q <= SEQ_IDLE;
			endcase
		end
	end

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.req_type <= req_type;
			item_s1.addr     <= word_address;
			item_s1.data     <= write_data;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manuf  <= DATA_W'(1);
			cfg_q.device <= '0;
			cfg_q.ticks  <= TICK_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MANUF:  cfg_q.manuf  <= cfg_data[DATA_W-1:0];
				CFG_DEVICE: cfg_q.device <= cfg_data[DATA_W-1:0];
				CFG_TICKS:  cfg_q.ticks  <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Array port: sweep writes, item writes in exec, otherwise read at the incoming address.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = word_address;
		ram_wdata = mem_wr.wdata;
		if (seq_q == SEQ_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = ERASED_WORD;
		end else if (exec && mem_wr.we) begin
			ram_we   = 1'b1;
			ram_addr = mem_wr.addr;
		end
	end

	nfci_array u_array (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rdata)
	);

	nfci_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.exec     (exec),
		.item     (item_s1),
		.cfg      (cfg_q),
		.rdata    (rdata),
		.mem_wr   (mem_wr),
		.rd       (rd),
		.busy_nxt (busy_nxt)
	);

	// Result register and its one-cycle strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= exec;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			read_data <= rd;
			busy_res  <= busy_nxt;
		end
	end

endmodule

`default_nettype wire
